/* rtl/core/semaphore_wait_queue_table_unit_macros.svh */
// assertion macros for the semaphore wait queue table unit
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_UNIT_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_UNIT_MACROS_SVH

// property that holds whenever reset is released
`define SWQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, including during reset
`define SWQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/swq_pkg.sv */
// ----------------------------------------------------------------------------
// swq_pkg
// types, codes and controller interface of the semaphore wait queue table
// ----------------------------------------------------------------------------
package swq_pkg;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned NumProc    = 16;
  localparam int unsigned DescW      = $clog2(NumEntries);
  localparam int unsigned ProcW      = 4;
  localparam int unsigned CountW     = $clog2(NumProc + 1);

  typedef logic [DescW-1:0]  desc_idx_t;
  typedef logic [ProcW-1:0]  proc_idx_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_OUT    = 2'd2,
    MODE_HEAD   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BLOCKED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sem_key;
    logic [3:0]  proc_id;
  } swq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] proc_out;
    logic       released;
  } swq_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the request
    logic scan_init; // reset scan index
    logic scan_step; // compare one descriptor, advance
    logic walk_init; // set up the queue walk for out
    logic walk_step; // follow one link
    logic commit;    // apply update and register the result
  } swq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic walk_done;
  } swq_stat_t;

endpackage

/* rtl/core/swq_ctrl.sv */
// ----------------------------------------------------------------------------
// swq_ctrl
// sequencer: search the descriptor table or, for out, walk a queue, then commit
// ----------------------------------------------------------------------------
module swq_ctrl import swq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic [1:0] mode_i,
  input  swq_stat_t stat_i,
  output swq_cmd_t  cmd_o,
  output logic      busy_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_WINIT  = 5'b00100,
    S_WALK   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d = (mode_i == MODE_OUT) ? S_WINIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = S_COMMIT;
      end
      S_WINIT: begin
        cmd_o.walk_init = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* rtl/core/swq_dp.sv */
// ----------------------------------------------------------------------------
// swq_dp
// descriptor table, process links, scan and walk registers, result register
// ----------------------------------------------------------------------------
module swq_dp import swq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  swq_in_t   req_i,
  input  swq_cmd_t  cmd_i,
  output swq_stat_t stat_o,
  output logic      res_valid_o,
  output swq_out_t  res_o
);

  // table state
  logic [NumEntries-1:0] dvalid_q;
  logic [31:0]           dkey_q   [NumEntries];
  proc_idx_t             dhead_q  [NumEntries];
  proc_idx_t             dtail_q  [NumEntries];
  count_t                dcount_q [NumEntries];
  proc_idx_t             pnext_q  [NumProc];
  desc_idx_t             pdesc_q  [NumProc];
  logic [NumProc-1:0]    pblk_q;

  // request and scan registers
  swq_in_t   req_q;
  logic [DescW:0] idx_q;
  logic      hit_q, free_q;
  desc_idx_t hit_d_q, free_d_q;
  // walk registers for out
  proc_idx_t prev_q;
  count_t    wi_q;
  logic      found_q, atHead_q;

  swq_out_t  res_q, res_d;
  logic      rv_q;

  desc_idx_t sidx;
  desc_idx_t od;
  proc_idx_t p;
  proc_idx_t cur;
  logic      scan_end, walk_end;

  assign sidx = idx_q[DescW-1:0];
  assign p    = req_q.proc_id;
  assign od   = pdesc_q[p];
  assign cur  = pnext_q[prev_q];
  assign scan_end = (idx_q == (DescW+1)'(NumEntries - 1)) || (idx_q[DescW] == 1'b1);
  // a process that is not waiting has no queue to walk
  assign walk_end = !pblk_q[p] || found_q || (wi_q >= dcount_q[od]);
  assign stat_o.scan_done = scan_end;
  assign stat_o.walk_done = walk_end;

  // scan, walk and request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.scan_init) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (dvalid_q[sidx] && dkey_q[sidx] == req_q.sem_key && !hit_q) begin
        hit_q   <= 1'b1;
        hit_d_q <= sidx;
      end
      if (!dvalid_q[sidx] && !free_q) begin
        free_q   <= 1'b1;
        free_d_q <= sidx;
      end
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.walk_init) begin
      prev_q   <= dhead_q[od];
      wi_q     <= count_t'(1);
      atHead_q <= (dhead_q[od] == p);
      found_q  <= (dhead_q[od] == p);
    end else if (cmd_i.walk_step && !walk_end) begin
      if (cur == p) found_q <= 1'b1;
      else prev_q <= cur;
      wi_q <= wi_q + 1'b1;
    end
  end

  // result of the current item
  always_comb begin
    res_d = '{status: ST_OK, proc_out: '0, released: 1'b0};
    case (req_q.mode)
      MODE_INSERT: begin
        if (pblk_q[p]) res_d.status = ST_BLOCKED;
        else if (!hit_q && !free_q) res_d.status = ST_FULL;
      end
      MODE_REMOVE, MODE_HEAD: begin
        if (!hit_q || dcount_q[hit_d_q] == '0) begin
          res_d.status = ST_NOTFOUND;
        end else begin
          res_d.proc_out = dhead_q[hit_d_q];
          if (req_q.mode == MODE_REMOVE && dcount_q[hit_d_q] == count_t'(1)) begin
            res_d.released = 1'b1;
          end
        end
      end
      default: begin
        if (!pblk_q[p] || !dvalid_q[od] || dcount_q[od] == '0 || !found_q) begin
          res_d.status = ST_NOTFOUND;
        end else begin
          res_d.proc_out = p;
          res_d.released = (dcount_q[od] == count_t'(1));
        end
      end
    endcase
  end

  // commit: table update and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
      pblk_q   <= '0;
      rv_q     <= 1'b0;
      res_q    <= '0;
      for (int i = 0; i < NumEntries; i++) dcount_q[i] <= '0;
    end else begin
      rv_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        res_q <= res_d;
        case (req_q.mode)
          MODE_INSERT: begin
            if (!pblk_q[p] && (hit_q || free_q)) begin
              if (hit_q) begin
                if (dcount_q[hit_d_q] == '0) dhead_q[hit_d_q] <= p;
                else pnext_q[dtail_q[hit_d_q]] <= p;
                dtail_q[hit_d_q]  <= p;
                dcount_q[hit_d_q] <= dcount_q[hit_d_q] + 1'b1;
                pdesc_q[p] <= hit_d_q;
              end else begin
                dvalid_q[free_d_q] <= 1'b1;
                dkey_q[free_d_q]   <= req_q.sem_key;
                dhead_q[free_d_q]  <= p;
                dtail_q[free_d_q]  <= p;
                dcount_q[free_d_q] <= count_t'(1);
                pdesc_q[p] <= free_d_q;
              end
              pnext_q[p] <= '0;
              pblk_q[p]  <= 1'b1;
            end
          end
          MODE_REMOVE, MODE_HEAD: begin
            if (hit_q && dcount_q[hit_d_q] != '0 && req_q.mode == MODE_REMOVE) begin
              pblk_q[dhead_q[hit_d_q]] <= 1'b0;
              dhead_q[hit_d_q] <= pnext_q[dhead_q[hit_d_q]];
              dcount_q[hit_d_q] <= dcount_q[hit_d_q] - 1'b1;
              if (dcount_q[hit_d_q] == count_t'(1)) begin
                dvalid_q[hit_d_q] <= 1'b0;
              end
            end
          end
          default: begin
            if (pblk_q[p] && dvalid_q[od] && dcount_q[od] != '0 && found_q) begin
              if (atHead_q) dhead_q[od] <= pnext_q[p];
              else begin
                pnext_q[prev_q] <= pnext_q[p];
                if (dtail_q[od] == p) dtail_q[od] <= prev_q;
              end
              pblk_q[p] <= 1'b0;
              dcount_q[od] <= dcount_q[od] - 1'b1;
              if (dcount_q[od] == count_t'(1)) begin
                dvalid_q[od] <= 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/semaphore_wait_queue_table_unit.sv */
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table_unit
// table of semaphore descriptors with fifo queues of blocked processes
// ----------------------------------------------------------------------------
// usage:
//   raise start with req_i while busy is low; the item is taken at that
//   edge and busy rises right after it.
//   insert, remove and head scan all 16 descriptors, one per cycle, for a
//   matching key and the lowest free entry.
//   out follows the queue links of the process's descriptor one per cycle,
//   ending at once when the process is at the head of its queue or not
//   waiting, and otherwise at the process's position behind the head.
//   result appears on res_o for one cycle with res_valid_o high; busy is
//   already low in that cycle, so the next item can be taken at the edge
//   that takes the result.
//   the receiver cannot stall; results must be taken when strobed.
//   reset clears all descriptor valid marks, counts and blocked marks.
// ----------------------------------------------------------------------------
`include "semaphore_wait_queue_table_unit_macros.svh"
module semaphore_wait_queue_table_unit import swq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  swq_in_t  req_i,
  output logic     res_valid_o,
  output swq_out_t res_o
);

  swq_cmd_t  cmd;
  swq_stat_t stat;

  // controller
  swq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (req_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // datapath
  swq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // checks
  `SWQ_ASSERT(a_res_while_busy, clk_i, rst_ni, res_valid_o |-> $past(busy), "result without work")
  `SWQ_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept did not start work")
  `SWQ_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd.scan_step, cmd.walk_step, cmd.commit}), "overlapping commands")

endmodule
